// ===== hw/rtl/grfq_pkg.sv =====
// ----------------------------------------------------------------------------
// Gas reading frame qualifier package
// Shared widths, register indexes, status codes and result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package grfq_pkg;

  localparam int unsigned ModeW    = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FrameLen = 9;
  localparam int unsigned FrameW   = FrameLen * ByteW;
  localparam int unsigned PpmW     = 23;
  localparam int unsigned MsW      = 24;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OutW     = 40;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [ByteW-1:0] FrameHeader = 8'hFF;
  localparam logic [ByteW-1:0] FailMax     = 8'hFF;
  localparam logic [MsW-1:0]   MsMax       = 24'hFF_FFFF;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK     = 3'd0,
    MODE_FRAME    = 3'd1,
    MODE_BUS_FAIL = 3'd2,
    MODE_DETECTED = 3'd3,
    MODE_LOST     = 3'd4
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_BUS_FAIL   = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_CHKSUM = 3'd3,
    ST_BAD_DEC    = 3'd4,
    ST_WRONG_GAS  = 3'd5,
    ST_BELOW_MIN  = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_READ_COMMAND = 3'd0,
    REG_GAS_TYPE     = 3'd1,
    REG_MIN_PPM      = 3'd2,
    REG_MAX_PPM      = 3'd3,
    REG_FAIL_LIMIT   = 3'd4,
    REG_STALE_MS     = 3'd5,
    REG_WARMUP_MS    = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [OutW-38:0]    pad;
    logic                sensor_present;
    logic                warming_up;
    logic [ByteW-1:0]    consecutive_fails;
    logic [StatusW-1:0]  status;
    logic [PpmW-1:0]     co_centi_ppm;
    logic                reading_valid;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gas_reading_frame_qualifier_core.sv =====
// ----------------------------------------------------------------------------
// Gas reading frame qualifier core
// Qualifies carbon monoxide readings from 9-byte sensor response frames.
// ----------------------------------------------------------------------------
// The slave stream carries one transaction per event: tuser holds the event
// kind (tick of one millisecond, received frame, bus failure, sensor detected,
// sensor lost) and tdata holds the nine frame bytes, byte 0 in the lowest bits.
// Every input transaction gives exactly one master transaction with the
// validity flag, the held concentration in hundredths of ppm, the status code,
// the failure count, the warmup flag and the presence flag.
// An accepted transaction is held in an input register; when it moves forward
// the qualifying logic updates the block state and loads the result register,
// which then offers the result. While the receiver does not stall, one
// transaction is taken in every cycle; the input register moves forward whenever
// the result register is empty or is being taken.
// When the receiver stalls, the result waits in its register and the input
// register fills; s_tready then drops until the master side moves.
// Reset clears all state and both registers and restores the configuration
// defaults. The APB port writes and reads the seven configuration registers at
// byte addresses 0 to 24; writes should only happen while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_reading_frame_qualifier_core (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  output logic                           s_tready,
  // frame_byte0 .. frame_byte8, 8 bits each
  input  wire  [grfq_pkg::FrameW-1:0]    s_tdata,
  // mode
  input  wire  [grfq_pkg::ModeW-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  wire                            m_tready,
  // reading_valid, co_centi_ppm[22:0], status[2:0], consecutive_fails[7:0],
  // warming_up, sensor_present, zero pad
  output logic [grfq_pkg::OutW-1:0]      m_tdata,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [grfq_pkg::AddrW-1:0]     paddr,
  input  wire  [grfq_pkg::DataW-1:0]     pwdata,
  output logic [grfq_pkg::DataW-1:0]     prdata,
  output logic                           pready
);

  import grfq_pkg::*;

  logic [ByteW-1:0] read_command;
  logic [ByteW-1:0] expected_gas_type;
  logic [PpmW-1:0]  min_centi_ppm;
  logic [PpmW-1:0]  max_centi_ppm;
  logic [ByteW-1:0] fail_limit;
  logic [MsW-1:0]   stale_ms;
  logic [MsW-1:0]   warmup_ms;

  logic             present_flag, present_flag_next;
  logic             valid_flag, valid_flag_next;
  logic [PpmW-1:0]  held_value, held_value_next;
  logic [ByteW-1:0] fail_counter, fail_counter_next;
  logic [MsW-1:0]   since_data_ms, since_data_ms_next;
  logic             had_data, had_data_next;
  logic [MsW-1:0]   warmup_elapsed_ms, warmup_elapsed_ms_next;
  logic             mismatch_seen, mismatch_seen_next;
  status_t          status_next;

  logic             in_valid;
  logic [ModeW-1:0] in_mode;
  logic [FrameW-1:0] in_data;
  logic             out_valid;
  result_t          out_result;
  result_t          result_next;
  logic             advance;
  logic             cfg_write;
  reg_index_t       cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      read_command      <= 8'd134;
      expected_gas_type <= 8'd4;
      min_centi_ppm     <= '0;
      max_centi_ppm     <= 23'd100000;
      fail_limit        <= 8'd3;
      stale_ms          <= 24'd10000;
      warmup_ms         <= 24'd60000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_READ_COMMAND: read_command      <= pwdata[ByteW-1:0];
        REG_GAS_TYPE:     expected_gas_type <= pwdata[ByteW-1:0];
        REG_MIN_PPM:      min_centi_ppm     <= pwdata[PpmW-1:0];
        REG_MAX_PPM:      max_centi_ppm     <= pwdata[PpmW-1:0];
        REG_FAIL_LIMIT:   fail_limit        <= pwdata[ByteW-1:0];
        REG_STALE_MS:     stale_ms          <= pwdata[MsW-1:0];
        REG_WARMUP_MS:    warmup_ms         <= pwdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_index)
      REG_READ_COMMAND: prdata = {{(DataW-ByteW){1'b0}}, read_command};
      REG_GAS_TYPE:     prdata = {{(DataW-ByteW){1'b0}}, expected_gas_type};
      REG_MIN_PPM:      prdata = {{(DataW-PpmW){1'b0}}, min_centi_ppm};
      REG_MAX_PPM:      prdata = {{(DataW-PpmW){1'b0}}, max_centi_ppm};
      REG_FAIL_LIMIT:   prdata = {{(DataW-ByteW){1'b0}}, fail_limit};
      REG_STALE_MS:     prdata = {{(DataW-MsW){1'b0}}, stale_ms};
      REG_WARMUP_MS:    prdata = {{(DataW-MsW){1'b0}}, warmup_ms};
      default:          prdata = '0;
    endcase
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_result;

  always_comb begin
    logic [ByteW-1:0] b [FrameLen];
    logic [ByteW-1:0] sum6, sum7;
    logic [15:0]      raw;
    logic [PpmW-1:0]  val;
    logic             dec_ok;
    logic             hdr_ok;
    logic             chk_ok;
    logic             fail;
    logic [ByteW-1:0] fail_inc;

    for (int i = 0; i < FrameLen; i++) begin
      b[i] = in_data[i*ByteW +: ByteW];
    end
    hdr_ok = (b[0] == FrameHeader) && (b[1] == read_command);
    sum6   = b[1] + b[2] + b[3] + b[4] + b[5] + b[6];
    sum7   = sum6 + b[7];
    chk_ok = (b[8] == ByteW'(8'd0 - sum7)) || (b[8] == ByteW'(8'd0 - sum6));
    raw    = {b[2], b[3]};
    dec_ok = 1'b1;
    case (b[5])
      8'd0:    val = ({7'd0, raw} << 6) + ({7'd0, raw} << 5) + ({7'd0, raw} << 2);
      8'd1:    val = ({7'd0, raw} << 3) + ({7'd0, raw} << 1);
      8'd2:    val = {7'd0, raw};
      default: begin
        val    = '0;
        dec_ok = 1'b0;
      end
    endcase
    fail_inc = (fail_counter < FailMax) ? fail_counter + 8'd1 : fail_counter;

    present_flag_next      = present_flag;
    valid_flag_next        = valid_flag;
    held_value_next        = held_value;
    fail_counter_next      = fail_counter;
    since_data_ms_next     = since_data_ms;
    had_data_next          = had_data;
    warmup_elapsed_ms_next = warmup_elapsed_ms;
    mismatch_seen_next     = mismatch_seen;
    status_next            = ST_OK;
    fail                   = 1'b0;

    if (present_flag && valid_flag && had_data && (since_data_ms > stale_ms)) begin
      valid_flag_next = 1'b0;
    end

    case (in_mode)
      MODE_TICK: begin
        if (warmup_elapsed_ms < MsMax) begin
          warmup_elapsed_ms_next = warmup_elapsed_ms + 24'd1;
        end
        if (had_data && (since_data_ms < MsMax)) begin
          since_data_ms_next = since_data_ms + 24'd1;
        end
      end
      MODE_FRAME: begin
        if (present_flag) begin
          if (!hdr_ok) begin
            fail        = 1'b1;
            status_next = ST_BAD_HEADER;
          end else if (!chk_ok) begin
            fail        = 1'b1;
            status_next = ST_BAD_CHKSUM;
          end else if (!dec_ok) begin
            fail        = 1'b1;
            status_next = ST_BAD_DEC;
          end else begin
            fail_counter_next  = '0;
            since_data_ms_next = '0;
            had_data_next      = 1'b1;
            if (b[4] != expected_gas_type) begin
              mismatch_seen_next = 1'b1;
              valid_flag_next    = 1'b0;
              status_next        = ST_WRONG_GAS;
            end else begin
              mismatch_seen_next = 1'b0;
              if (val < min_centi_ppm) begin
                valid_flag_next = 1'b0;
                status_next     = ST_BELOW_MIN;
              end else begin
                held_value_next = (val > max_centi_ppm) ? max_centi_ppm : val;
                valid_flag_next = !(warmup_elapsed_ms < warmup_ms);
              end
            end
          end
        end
      end
      MODE_BUS_FAIL: begin
        if (present_flag) begin
          fail        = 1'b1;
          status_next = ST_BUS_FAIL;
        end
      end
      MODE_DETECTED: begin
        if (!present_flag) begin
          present_flag_next      = 1'b1;
          warmup_elapsed_ms_next = '0;
          valid_flag_next        = 1'b0;
          held_value_next        = '0;
          fail_counter_next      = '0;
          mismatch_seen_next     = 1'b0;
        end
      end
      MODE_LOST: begin
        present_flag_next  = 1'b0;
        valid_flag_next    = 1'b0;
        held_value_next    = '0;
        fail_counter_next  = '0;
        mismatch_seen_next = 1'b0;
      end
      default: ;
    endcase

    if (fail) begin
      fail_counter_next = fail_inc;
      if (fail_inc >= fail_limit) begin
        valid_flag_next = 1'b0;
      end
    end

    result_next                   = '0;
    result_next.reading_valid     = valid_flag_next;
    result_next.co_centi_ppm      = held_value_next;
    result_next.status            = status_next;
    result_next.consecutive_fails = fail_counter_next;
    result_next.warming_up        = present_flag_next &&
                                    (warmup_elapsed_ms_next < warmup_ms);
    result_next.sensor_present    = present_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      present_flag      <= 1'b0;
      valid_flag        <= 1'b0;
      held_value        <= '0;
      fail_counter      <= '0;
      since_data_ms     <= '0;
      had_data          <= 1'b0;
      warmup_elapsed_ms <= '0;
      mismatch_seen     <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid         <= 1'b1;
        present_flag      <= present_flag_next;
        valid_flag        <= valid_flag_next;
        held_value        <= held_value_next;
        fail_counter      <= fail_counter_next;
        since_data_ms     <= since_data_ms_next;
        had_data          <= had_data_next;
        warmup_elapsed_ms <= warmup_elapsed_ms_next;
        mismatch_seen     <= mismatch_seen_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_data <= s_tdata;
    end
    if (advance) begin
      out_result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/grfq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas reading frame qualifier checker
// Watches the input stream, the result stream and the register port. It keeps
// its own copy of the qualifier state and configuration, and works out the
// result of every accepted input transaction. Results are checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module grfq_checker
  import grfq_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  input  wire                s_tready,
  input  wire  [FrameW-1:0]  s_tdata,
  input  wire  [ModeW-1:0]   s_tuser,
  input  wire                m_tvalid,
  input  wire                m_tready,
  input  wire  [OutW-1:0]    m_tdata,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire                pready,
  input  wire  [AddrW-1:0]   paddr,
  input  wire  [DataW-1:0]   pwdata,
  output int unsigned        mismatch_count,
  output int unsigned        pending_results,
  output int unsigned        results_checked
);

  result_t predicted_readings[$];

  logic [ByteW-1:0] cfg_cmd;
  logic [ByteW-1:0] cfg_gas;
  logic [PpmW-1:0]  cfg_min;
  logic [PpmW-1:0]  cfg_max;
  logic [ByteW-1:0] cfg_fail_limit;
  logic [MsW-1:0]   cfg_stale;
  logic [MsW-1:0]   cfg_warmup;

  logic             present_q;
  logic             valid_q;
  logic [PpmW-1:0]  held_q;
  logic [ByteW-1:0] fails_q;
  logic [MsW-1:0]   since_q;
  logic             had_data_q;
  logic [MsW-1:0]   warm_q;
  logic             mismatch_q;

  function automatic logic warming_now();
    return present_q && (warm_q < cfg_warmup);
  endfunction

  task automatic count_failure();
    if (fails_q != FailMax) fails_q++;
    if (fails_q >= cfg_fail_limit) valid_q = 1'b0;
  endtask

  task automatic qualify_frame(input logic [FrameW-1:0] frame, output status_t st);
    logic [ByteW-1:0] b [FrameLen];
    logic [ByteW-1:0] sum6;
    logic [ByteW-1:0] sum7;
    logic [PpmW-1:0]  reading;
    for (int i = 0; i < FrameLen; i++) b[i] = frame[i*ByteW +: ByteW];
    st = ST_OK;
    sum6 = b[1] + b[2] + b[3] + b[4] + b[5] + b[6];
    sum7 = sum6 + b[7];
    if (b[0] != FrameHeader || b[1] != cfg_cmd) begin
      count_failure();
      st = ST_BAD_HEADER;
    end else if (b[8] != 8'(8'd0 - sum7) && b[8] != 8'(8'd0 - sum6)) begin
      count_failure();
      st = ST_BAD_CHKSUM;
    end else if (b[5] > 8'd2) begin
      count_failure();
      st = ST_BAD_DEC;
    end else begin
      if (b[5] == 8'd0) reading = PpmW'({b[2], b[3]} * 100);
      else if (b[5] == 8'd1) reading = PpmW'({b[2], b[3]} * 10);
      else reading = PpmW'({b[2], b[3]});
      fails_q = '0;
      since_q = '0;
      had_data_q = 1'b1;
      if (b[4] != cfg_gas) begin
        mismatch_q = 1'b1;
        valid_q = 1'b0;
        st = ST_WRONG_GAS;
      end else begin
        mismatch_q = 1'b0;
        if (reading < cfg_min) begin
          valid_q = 1'b0;
          st = ST_BELOW_MIN;
        end else begin
          if (reading > cfg_max) reading = cfg_max;
          held_q = reading;
          valid_q = !warming_now();
        end
      end
    end
  endtask

  task automatic qualify_event(input logic [ModeW-1:0] kind, input logic [FrameW-1:0] frame,
                               output result_t res);
    status_t st;
    st = ST_OK;
    if (present_q && valid_q && had_data_q && since_q > cfg_stale) valid_q = 1'b0;
    case (kind)
      MODE_TICK: begin
        if (warm_q != MsMax) warm_q++;
        if (had_data_q && since_q != MsMax) since_q++;
      end
      MODE_FRAME: begin
        if (present_q) qualify_frame(frame, st);
      end
      MODE_BUS_FAIL: begin
        if (present_q) begin
          count_failure();
          st = ST_BUS_FAIL;
        end
      end
      MODE_DETECTED: begin
        if (!present_q) begin
          present_q = 1'b1;
          warm_q = '0;
          valid_q = 1'b0;
          held_q = '0;
          fails_q = '0;
          mismatch_q = 1'b0;
        end
      end
      MODE_LOST: begin
        present_q = 1'b0;
        valid_q = 1'b0;
        held_q = '0;
        fails_q = '0;
        mismatch_q = 1'b0;
      end
      default: ;
    endcase
    res = '0;
    res.reading_valid = valid_q;
    res.co_centi_ppm = held_q;
    res.status = st;
    res.consecutive_fails = fails_q;
    res.warming_up = warming_now();
    res.sensor_present = present_q;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      cfg_cmd = 8'd134;
      cfg_gas = 8'd4;
      cfg_min = '0;
      cfg_max = PpmW'(100000);
      cfg_fail_limit = 8'd3;
      cfg_stale = MsW'(10000);
      cfg_warmup = MsW'(60000);
      present_q = 1'b0;
      valid_q = 1'b0;
      held_q = '0;
      fails_q = '0;
      since_q = '0;
      had_data_q = 1'b0;
      warm_q = '0;
      mismatch_q = 1'b0;
      predicted_readings.delete();
      mismatch_count = 0;
      results_checked = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[AddrW-1:2]))
          REG_READ_COMMAND: cfg_cmd = pwdata[ByteW-1:0];
          REG_GAS_TYPE:     cfg_gas = pwdata[ByteW-1:0];
          REG_MIN_PPM:      cfg_min = pwdata[PpmW-1:0];
          REG_MAX_PPM:      cfg_max = pwdata[PpmW-1:0];
          REG_FAIL_LIMIT:   cfg_fail_limit = pwdata[ByteW-1:0];
          REG_STALE_MS:     cfg_stale = pwdata[MsW-1:0];
          REG_WARMUP_MS:    cfg_warmup = pwdata[MsW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        qualify_event(s_tuser, s_tdata, want);
        predicted_readings.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (predicted_readings.size() == 0) begin
          $display("%0t: result transaction expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = predicted_readings.pop_front();
          compare_field("reading_valid", want.reading_valid, got.reading_valid);
          compare_field("co_centi_ppm", want.co_centi_ppm, got.co_centi_ppm);
          compare_field("status", want.status, got.status);
          compare_field("consecutive_fails", want.consecutive_fails, got.consecutive_fails);
          compare_field("warming_up", want.warming_up, got.warming_up);
          compare_field("sensor_present", want.sensor_present, got.sensor_present);
          results_checked++;
        end
      end
    end
    pending_results <= predicted_readings.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas reading frame qualifier testbench
// Drives sensor events and frames into the qualifier core in random bursts,
// stalls the result side on its own pattern, and walks through several
// register settings. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import grfq_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 120;

  typedef enum int unsigned {
    CHK_LONG,
    CHK_SHORT,
    CHK_BROKEN
  } chk_kind_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [FrameW-1:0] s_tdata = '0;
  logic [ModeW-1:0]  s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OutW-1:0]   m_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned results_checked;
  int unsigned cycle_count = 0;
  int unsigned events_sent = 0;
  int unsigned settings_used = 0;
  int unsigned hold_request = 0;
  int unsigned burst_left = 0;
  logic        sensor_on = 1'b0;
  logic [7:0]  cur_cmd = 8'd134;
  logic [7:0]  cur_gas = 8'd4;

  always #5 clk = ~clk;

  gas_reading_frame_qualifier_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  grfq_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver changes its stall rate from run to run and serves long
  // hold-off requests while the sender keeps offering transactions.
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned run_left;
    int unsigned hold_left;
    int unsigned holds_served;
    stall_pct = 0;
    run_left = 0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_request) begin
        holds_served = hold_request;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(8, 64);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        run_left--;
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [FrameW-1:0] build_frame(
    input logic [7:0] hdr, input logic [7:0] cmd, input logic [15:0] raw,
    input logic [7:0] gas, input logic [7:0] dec, input logic [7:0] b6,
    input logic [7:0] b7, input chk_kind_t chk);
    logic [7:0] sum6;
    logic [7:0] sum7;
    logic [7:0] chk_byte;
    sum6 = cmd + raw[15:8] + raw[7:0] + gas + dec + b6;
    sum7 = sum6 + b7;
    case (chk)
      CHK_LONG:  chk_byte = 8'd0 - sum7;
      CHK_SHORT: chk_byte = 8'd0 - sum6;
      default: begin
        chk_byte = 8'($urandom_range(0, 255));
        while (chk_byte == 8'(8'd0 - sum7) || chk_byte == 8'(8'd0 - sum6)) chk_byte++;
      end
    endcase
    return {chk_byte, b7, b6, dec, gas, raw[7:0], raw[15:8], cmd, hdr};
  endfunction

  task automatic send_event(input logic [ModeW-1:0] kind, input logic [FrameW-1:0] frame);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tuser <= kind;
    s_tdata <= frame;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (kind == MODE_DETECTED) sensor_on = 1'b1;
    if (kind == MODE_LOST) sensor_on = 1'b0;
    events_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic apb_write(input reg_index_t idx, input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_settings(
    input int unsigned cmd, input int unsigned gas, input int unsigned min_ppm,
    input int unsigned max_ppm, input int unsigned limit, input int unsigned stale,
    input int unsigned warmup);
    drain();
    apb_write(REG_READ_COMMAND, cmd);
    apb_write(REG_GAS_TYPE, gas);
    apb_write(REG_MIN_PPM, min_ppm);
    apb_write(REG_MAX_PPM, max_ppm);
    apb_write(REG_FAIL_LIMIT, limit);
    apb_write(REG_STALE_MS, stale);
    apb_write(REG_WARMUP_MS, warmup);
    cur_cmd = cmd[7:0];
    cur_gas = gas[7:0];
    settings_used++;
  endtask

  task automatic send_random_event(output bit counted);
    int unsigned pick;
    logic [7:0]  hdr;
    logic [7:0]  cmd;
    logic [7:0]  gas;
    logic [7:0]  dec;
    logic [15:0] raw;
    logic [95:0] noise;
    chk_kind_t   chk;
    hdr = FrameHeader;
    cmd = cur_cmd;
    gas = cur_gas;
    dec = 8'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: raw = 16'($urandom_range(0, 255));
      1: raw = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
      default: raw = 16'($urandom_range(0, 65535));
    endcase
    chk = ($urandom_range(0, 1) == 0) ? CHK_LONG : CHK_SHORT;
    noise = {$urandom, $urandom, $urandom};
    counted = sensor_on;
    if (!sensor_on) begin
      if ($urandom_range(0, 3) != 0) send_event(MODE_DETECTED, noise[FrameW-1:0]);
      else send_event(ModeW'($urandom_range(0, 7)), noise[FrameW-1:0]);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_event(MODE_TICK, noise[FrameW-1:0]);
      end else if (pick < 70) begin
        if ($urandom_range(0, 9) == 0) gas = 8'($urandom_range(0, 255));
        send_event(MODE_FRAME, build_frame(hdr, cmd, raw, gas, dec, noise[7:0],
                                           noise[15:8], chk));
      end else if (pick < 78) begin
        send_event(MODE_BUS_FAIL, noise[FrameW-1:0]);
      end else if (pick < 88) begin
        case ($urandom_range(0, 3))
          0: hdr = 8'($urandom_range(0, 254));
          1: cmd = cur_cmd ^ 8'($urandom_range(1, 255));
          2: chk = CHK_BROKEN;
          default: dec = 8'($urandom_range(3, 255));
        endcase
        send_event(MODE_FRAME, build_frame(hdr, cmd, raw, gas, dec, noise[7:0],
                                           noise[15:8], chk));
      end else if (pick < 92) begin
        send_event(MODE_FRAME, noise[FrameW-1:0]);
      end else if (pick < 95) begin
        send_event(MODE_LOST, noise[FrameW-1:0]);
      end else if (pick < 97) begin
        send_event(MODE_DETECTED, noise[FrameW-1:0]);
      end else begin
        send_event(ModeW'($urandom_range(5, 7)), noise[FrameW-1:0]);
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned done;
    bit counted;
    done = 0;
    while (done < count) begin
      send_random_event(counted);
      if (counted) done++;
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h1234, 8'd4, 8'd0, 8'h00, 8'h00,
                                       CHK_LONG));
    send_event(MODE_BUS_FAIL, '0);
    send_event(MODE_LOST, '0);
    send_event(MODE_DETECTED, '0);
    send_event(MODE_DETECTED, '1);
    send_event(MODE_TICK, '0);
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'hFFFF, 8'd4, 8'd0, 8'hFF, 8'hFF,
                                       CHK_LONG));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0100, 8'd4, 8'd1, 8'hAA, 8'h55,
                                       CHK_SHORT));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0000, 8'd4, 8'd2, 8'h00, 8'h00,
                                       CHK_LONG));
    send_event(MODE_FRAME, build_frame(8'h00, 8'd134, 16'h0042, 8'd4, 8'd0, 8'h00, 8'h00,
                                       CHK_LONG));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'h79, 16'h0042, 8'd4, 8'd0, 8'h00, 8'h00,
                                       CHK_LONG));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0042, 8'd4, 8'd0, 8'h00, 8'h00,
                                       CHK_BROKEN));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0042, 8'd4, 8'd3, 8'h00, 8'h00,
                                       CHK_LONG));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0042, 8'd4, 8'hFF, 8'h00, 8'h00,
                                       CHK_SHORT));
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0042, 8'hFB, 8'd0, 8'h00, 8'h00,
                                       CHK_LONG));
    repeat (3) send_event(MODE_BUS_FAIL, '0);
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd134, 16'h0321, 8'd4, 8'd1, 8'h12, 8'h34,
                                       CHK_SHORT));
    send_event(3'd5, '0);
    send_event(3'd7, '1);
    send_event(MODE_LOST, '0);
    send_event(MODE_TICK, '0);

    program_settings(134, 4, 0, 6553500, 1, 0, 0);
    hold_request++;
    run_random(100);

    program_settings(255, 255, 6553500, 6553500, 255, MsMax, MsMax);
    if (!sensor_on) send_event(MODE_DETECTED, '0);
    for (int i = 0; i < 260; i++) begin
      if (i % 3 == 0) begin
        send_event(MODE_FRAME, build_frame(8'h7F, 8'd255, 16'hFFFF, 8'd255, 8'd0, 8'h00,
                                           8'h00, CHK_LONG));
      end else begin
        send_event(MODE_BUS_FAIL, '0);
      end
    end
    send_event(MODE_FRAME, build_frame(8'hFF, 8'd255, 16'hFFFF, 8'd255, 8'd0, 8'h00, 8'h00,
                                       CHK_LONG));
    run_random(80);

    program_settings(0, 0, 100000, 50000, 3, 25, 8);
    run_random(100);

    for (int p = 0; p < 4; p++) begin
      int unsigned min_ppm;
      min_ppm = $urandom_range(0, 200000);
      program_settings($urandom_range(0, 255), $urandom_range(0, 255), min_ppm,
                       min_ppm + $urandom_range(0, 400000), $urandom_range(1, 6),
                       $urandom_range(3, 60), $urandom_range(0, 40));
      if (p == 0) hold_request++;
      run_random(85);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d events under %0d register settings; %0d results compared.",
             events_sent, settings_used + 1, results_checked);
    $display("Run included a saturating failure streak and long result-side hold-offs.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
